// ----- hdl/brfo_pkg.sv -----
// Shared types and constants of the byte ring FIFO with overwrite.
package brfo_pkg;

  // Store geometry
  localparam int unsigned DEPTH = 256;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;

  // Configuration register indexes
  localparam logic [0:0] CFG_OVERWRITE = 1'b0;
  localparam logic [0:0] CFG_CAPACITY  = 1'b1;

  // Request kind
  typedef enum logic [0:0] {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_WRITTEN  = 2'd0,
    ST_REJECTED = 2'd1,
    ST_READ     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Input request
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic        burst_first;
    logic [15:0] burst_length;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_e     status;
    logic [7:0]  read_data;
    logic        read_valid;
    logic [8:0]  fill_level;
    logic        is_empty;
  } out_item_t;

  // Control-side part of a result, registered in the top level
  typedef struct packed {
    status_e     status;
    logic        read_valid;
    logic [8:0]  fill_level;
    logic        is_empty;
  } res_t;

  // Store access for one request
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

// ----- hdl/brfo_ram.sv -----
// Byte store of the ring FIFO: one write port, one registered read port.
module brfo_ram (
  input  logic               clk_i,
  input  brfo_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [brfo_pkg::DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/brfo_ctrl.sv -----
// Ring pointers, fill count, burst admission and configuration registers.
module brfo_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [8:0]         cfg_wdata_i,
  input  logic               acc_i,
  input  brfo_pkg::in_item_t item_i,
  output brfo_pkg::mem_req_t mem_req_o,
  output brfo_pkg::res_t     res_o
);

  logic                   ow_q;
  logic [8:0]             cap_q;
  logic [brfo_pkg::AW-1:0] wr_q, wr_d;
  logic [brfo_pkg::AW-1:0] rd_q, rd_d;
  logic [brfo_pkg::CW-1:0] cnt_q, cnt_d;
  logic                   drop_q, drop_d;
  logic [8:0]             free;
  logic [brfo_pkg::AW-1:0] wr_adv, rd_adv;
  logic                   wr_ok;

  // Next index, wrapping at the capacity in use
  function automatic logic [brfo_pkg::AW-1:0] advance(
    input logic [brfo_pkg::AW-1:0] idx,
    input logic [8:0]              cap
  );
    logic [8:0] n;
    n = {1'b0, idx} + 9'd1;
    return (n >= cap) ? '0 : n[brfo_pkg::AW-1:0];
  endfunction

  // Configuration; capacity is clamped to 1..DEPTH on the way in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_q  <= 1'b0;
      cap_q <= 9'(brfo_pkg::DEPTH);
    end else if (cfg_we_i) begin
      if (cfg_index_i == brfo_pkg::CFG_OVERWRITE) begin
        ow_q <= cfg_wdata_i[0];
      end else if (cfg_index_i == brfo_pkg::CFG_CAPACITY) begin
        if (cfg_wdata_i == 9'd0) begin
          cap_q <= 9'd1;
        end else if (cfg_wdata_i > 9'(brfo_pkg::DEPTH)) begin
          cap_q <= 9'(brfo_pkg::DEPTH);
        end else begin
          cap_q <= cfg_wdata_i;
        end
      end
    end
  end

  // Request decode and state update
  always_comb begin
    free   = (cap_q > cnt_q) ? cap_q - cnt_q : 9'd0;
    wr_adv = advance(wr_q, cap_q);
    rd_adv = advance(rd_q, cap_q);
    wr_d   = wr_q;
    rd_d   = rd_q;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    wr_ok  = 1'b0;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wr_q;
    mem_req_o.wdata = item_i.data_byte;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = rd_q;

    res_o.status     = brfo_pkg::ST_WRITTEN;
    res_o.read_valid = 1'b0;

    if (item_i.kind == brfo_pkg::KIND_WRITE) begin
      // Admission is decided on the first byte of a burst; with overwriting, every byte is written
      if (ow_q) begin
        if (item_i.burst_first) begin
          drop_d = 1'b0;
        end
        wr_ok = 1'b1;
      end else begin
        if (item_i.burst_first) begin
          drop_d = item_i.burst_length > {7'd0, free};
        end
        wr_ok = !drop_d && (free != 9'd0);
      end
      if (wr_ok) begin
        mem_req_o.we = acc_i;
        wr_d = wr_adv;
        // Full: oldest byte is overwritten, read index follows
        if (cnt_q >= cap_q) begin
          rd_d  = wr_adv;
          cnt_d = cap_q;
        end else begin
          cnt_d = cnt_q + 9'd1;
        end
        res_o.status = brfo_pkg::ST_WRITTEN;
      end else begin
        res_o.status = brfo_pkg::ST_REJECTED;
      end
    end else begin
      if (cnt_q == '0) begin
        res_o.status = brfo_pkg::ST_EMPTY;
      end else begin
        mem_req_o.re     = acc_i;
        rd_d             = rd_adv;
        cnt_d            = cnt_q - 9'd1;
        res_o.status     = brfo_pkg::ST_READ;
        res_o.read_valid = 1'b1;
      end
    end

    res_o.fill_level = cnt_d;
    res_o.is_empty   = (cnt_d == '0);
  end

  // Ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (acc_i) begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ----- hdl/byte_ring_fifo_overwrite.sv -----
// Top level of the byte ring FIFO with overwrite.
//
// Each input request is one byte operation: a write (kind 0) or a read
// (kind 1). Write bursts are admitted on their first byte against the free
// space, unless overwriting is enabled, in which case a full buffer drops its
// oldest byte instead. Every request yields exactly one result carrying a
// status, read data, fill level and an empty flag.
// Channels use valid/stall: a request moves on a clock edge with valid high
// and stall low. The configuration port writes register 0 (overwrite
// enable) or register 1 (capacity in use, clamped to 1..256) on any edge with
// cfg_we_i high; write it only while no request is in flight.
// The result is registered at the edge that accepts the request, together with
// the byte read from the store's registered read port. Throughput is one
// request per cycle while the receiver does not stall.
// Reset empties the ring, clears burst dropping, disables overwriting and sets
// the capacity to 256; the byte store itself is not cleared.
// While the receiver stalls, the result holds and in_stall_o is raised so no
// further request is taken until the result is taken.
module byte_ring_fifo_overwrite (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [8:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brfo_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output brfo_pkg::out_item_t out_data_o
);

  logic               acc;
  logic               out_valid_q;
  brfo_pkg::res_t     res, res_q;
  brfo_pkg::mem_req_t mem_req;
  logic [7:0]         rdata;

  // Input handshake: blocked only while a result waits on a stalled receiver
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  brfo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .item_i      (in_data_i),
    .mem_req_o   (mem_req),
    .res_o       (res)
  );

  brfo_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  // Output assembly; read data is zero unless a byte was taken
  assign out_valid_o           = out_valid_q;
  assign out_data_o.status     = res_q.status;
  assign out_data_o.read_data  = res_q.read_valid ? rdata : 8'd0;
  assign out_data_o.read_valid = res_q.read_valid;
  assign out_data_o.fill_level = res_q.fill_level;
  assign out_data_o.is_empty   = res_q.is_empty;

`ifndef NO_ASSERTIONS
  // A byte is handed out only with the read status
  a_rvalid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.read_valid == (out_data_o.status == brfo_pkg::ST_READ)))
    else $error("read_valid disagrees with status");

  // A read that found nothing leaves the ring empty
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == brfo_pkg::ST_EMPTY))
      |-> (out_data_o.fill_level == 9'd0) && out_data_o.is_empty)
    else $error("empty read with nonzero fill level");

  // The fill level never exceeds the store depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fill_level <= 9'(brfo_pkg::DEPTH)))
    else $error("fill level beyond store depth");

  // A successful read lowers the fill level by one from the previous result
  a_read_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) ##1
    (out_valid_o && $rose(out_valid_o) == 1'b0 &&
     out_data_o.status == brfo_pkg::ST_READ && !$stable(out_data_o))
      |-> (out_data_o.fill_level == $past(out_data_o.fill_level) - 9'd1))
    else $error("read did not lower fill level by one");
`endif

endmodule
